// ===== hdl/bitmap_set_clear_find_engine_assert.svh =====
// Assertion macros used by the checker of the bitmap engine.
`ifndef BITMAP_SET_CLEAR_FIND_ENGINE_ASSERT_SVH
`define BITMAP_SET_CLEAR_FIND_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bitmap engine assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bitmap engine assertion failed");

`endif

// ===== hdl/bscf_pkg.sv =====
package bscf_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned END_W   = 13;
  localparam int unsigned WIDX_W  = 6;
  localparam int unsigned OPW_W   = 64;
  localparam int unsigned MOP_W   = 2;
  localparam int unsigned FIDX_W  = 12;
  localparam int unsigned CFG_W   = 7;

  // Bit count of the used words: at most 127 words of 64 bits.
  localparam int unsigned NB_W    = 13;
  // Word counter: a start position over an 8-bit word reaches word 511.
  localparam int unsigned WCNT_W  = 10;
  // Bit base of a word, with room for one step past the used size.
  localparam int unsigned LO_W    = 14;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam int unsigned DEF_WORD_BITS = 64;
  localparam int unsigned DEF_PAGES     = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_RANGE = 3'd2,
    CMD_FIND  = 3'd3,
    CMD_MERGE = 3'd4
  } cmd_e;

  typedef enum logic [MOP_W-1:0] {
    MOP_OR  = 2'd0,
    MOP_AND = 2'd1,
    MOP_XOR = 2'd2
  } mop_e;

endpackage

// ===== hdl/bscf_if.sv =====
interface bscf_req_if import bscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  bit_index;
  logic [END_W-1:0]  range_end;
  logic              bit_value;
  logic [WIDX_W-1:0] word_index;
  logic [OPW_W-1:0]  operand_word;
  logic [MOP_W-1:0]  merge_op;

  modport source (output valid, command, bit_index, range_end, bit_value, word_index,
                  operand_word, merge_op, input ready);
  modport sink (input valid, command, bit_index, range_end, bit_value, word_index,
                operand_word, merge_op, output ready);
endinterface

interface bscf_rsp_if import bscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              flag;
  logic              found;
  logic [FIDX_W-1:0] found_index;

  modport source (output valid, flag, found, found_index, input ready);
  modport sink (input valid, flag, found, found_index, output ready);
endinterface

interface bscf_cfg_if import bscf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] pages_in_use;

  modport source (output valid, pages_in_use, input ready);
  modport sink (input valid, pages_in_use, output ready);
endinterface

// ===== hdl/bitmap_set_clear_find_engine.sv =====
// Channel  | Dir | Modport | Carries
// req_i    | in  | sink    | command, bit_index, range_end, bit_value, word_index,
//          |     |         | operand_word, merge_op
// rsp_o    | out | source  | flag, found, found_index
// cfg_i    | in  | sink    | pages_in_use (always ready)
//
// Read, write bit and merge step through decode (S_DIV, S_REM), memory read, modify and
// write back, and result; read and modify are skipped when the word is not in use or the
// command is undefined. A range write and a find pass through the read and the modify
// state once for each word visited.
// After reset a clearing pass writes zero to all PAGES words, one a cycle, before any item.
// While a result is stalled at the output, the next item runs and waits in its last state.
module bitmap_set_clear_find_engine import bscf_pkg::*; #(
  parameter int unsigned WORD_BITS = DEF_WORD_BITS,
  parameter int unsigned PAGES     = DEF_PAGES
) (
  input logic       clk_i,
  input logic       rst_ni,
  bscf_req_if.sink  req_i,
  bscf_rsp_if.source rsp_o,
  bscf_cfg_if.sink  cfg_i
);

  localparam int unsigned AW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned RW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned SH    = 24;
  localparam int unsigned RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned PR_W  = SH + WCNT_W;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_REM  = 7'b0001000,
    S_RD   = 7'b0010000,
    S_MOD  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CFG_W-1:0] cfg_q;

  logic [CMD_W-1:0]     cmd_q;
  logic [POS_W-1:0]     pos_q;
  logic [END_W-1:0]     end_q;
  logic                 val_q;
  logic [WIDX_W-1:0]    widx_q;
  logic [WORD_BITS-1:0] opw_q;
  logic [MOP_W-1:0]     mop_q;

  logic [WCNT_W-1:0] q_q, q_d;
  logic [CFG_W-1:0]  used_q, used_d;
  logic [NB_W-1:0]   nbits_q, nbits_d;
  logic [WCNT_W-1:0] w_q, w_d;
  logic [LO_W-1:0]   lo_q, lo_d;
  logic              first_q, first_d;

  logic              flag_q, flag_d;
  logic              found_q, found_d;
  logic [FIDX_W-1:0] fidx_q, fidx_d;

  logic              out_valid_q;
  logic              out_flag_q;
  logic              out_found_q;
  logic [FIDX_W-1:0] out_fidx_q;
  logic              out_load;

  logic [WORD_BITS-1:0] mem [PAGES];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic                 accept;
  logic [PR_W-1:0]      prod;
  logic [RW-1:0]        rem;
  logic [NB_W-1:0]      to_c;
  logic [LO_W-1:0]      span;
  logic [RW:0]          s_off, e_off;
  logic [WORD_BITS-1:0] rng_mask, low_mask, bit_mask, nw, x;
  logic                 in_use, go;

  function automatic logic [RW-1:0] low_bit(input logic [WORD_BITS-1:0] v);
    logic [RW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = RW'(i);
    end
    return idx;
  endfunction

  assign accept       = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready  = 1'b1;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.flag        = out_flag_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.found_index = out_fidx_q;

  // Word number of a position by multiplying with the rounded-up reciprocal;
  // exact for every 12-bit position.
  assign prod = PR_W'(pos_q) * PR_W'(RECIP);
  assign rem  = RW'(pos_q - lo_q[POS_W-1:0]);
  assign to_c = ({1'b0, end_q[END_W-1:0]} > {1'b0, nbits_q}) ? nbits_q : NB_W'(end_q);
  assign span = LO_W'(to_c) - lo_q;
  assign in_use = (w_q < WCNT_W'(used_q));

  always_comb begin
    s_off = first_q ? {1'b0, rem} : '0;
    e_off = (span >= LO_W'(WORD_BITS)) ? (RW + 1)'(WORD_BITS) : span[RW:0];
    for (int j = 0; j < WORD_BITS; j++) begin
      low_mask[j] = ((RW + 1)'(j) < s_off);
      rng_mask[j] = !low_mask[j] && ((RW + 1)'(j) < e_off);
    end
    bit_mask = WORD_BITS'(1) << rem;
    x = (val_q ? rdata_q : ~rdata_q) & ~low_mask;
  end

  always_comb begin
    nw = rdata_q;
    case (cmd_q)
      CMD_WRITE: nw = val_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
      CMD_RANGE: nw = val_q ? (rdata_q | rng_mask) : (rdata_q & ~rng_mask);
      CMD_MERGE: begin
        case (mop_q)
          MOP_OR:  nw = rdata_q | opw_q;
          MOP_AND: nw = rdata_q & opw_q;
          MOP_XOR: nw = rdata_q ^ opw_q;
          default: nw = rdata_q;
        endcase
      end
      default: nw = rdata_q;
    endcase
  end

  always_comb begin
    go = 1'b0;
    case (cmd_q)
      CMD_READ, CMD_WRITE, CMD_FIND: go = in_use;
      CMD_RANGE: go = in_use && (first_q ? ({1'b0, to_c} > LO_W'(pos_q))
                                         : (LO_W'(to_c) > lo_q));
      CMD_MERGE: go = in_use && (mop_q == MOP_OR || mop_q == MOP_AND || mop_q == MOP_XOR);
      default:   go = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    q_d       = q_q;
    used_d    = used_q;
    nbits_d   = nbits_q;
    w_d       = w_q;
    lo_d      = lo_q;
    first_d   = first_q;
    flag_d    = flag_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = w_q[AW-1:0];
    mem_wdata = nw;
    out_load  = 1'b0;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          flag_d  = 1'b0;
          found_d = 1'b0;
          fidx_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        q_d     = prod[SH +: WCNT_W];
        used_d  = ({4'b0, cfg_q} > 11'(PAGES)) ? CFG_W'(PAGES) : cfg_q;
        state_d = S_REM;
      end
      S_REM: begin
        nbits_d = NB_W'(used_q) * NB_W'(WORD_BITS);
        lo_d    = LO_W'(q_q) * LO_W'(WORD_BITS);
        w_d     = (cmd_q == CMD_MERGE) ? WCNT_W'(widx_q) : q_q;
        first_d = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        if (go) begin
          mem_re  = 1'b1;
          state_d = S_MOD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOD: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_READ: flag_d = rdata_q[rem];
          CMD_WRITE, CMD_MERGE: begin
            mem_we = 1'b1;
            flag_d = (nw != rdata_q);
          end
          CMD_RANGE: begin
            mem_we  = 1'b1;
            flag_d  = flag_q || (nw != rdata_q);
            w_d     = w_q + WCNT_W'(1);
            lo_d    = lo_q + LO_W'(WORD_BITS);
            first_d = 1'b0;
            state_d = S_RD;
          end
          CMD_FIND: begin
            if (|x) begin
              found_d = 1'b1;
              fidx_d  = FIDX_W'(lo_q + LO_W'(low_bit(x)));
            end else begin
              w_d     = w_q + WCNT_W'(1);
              lo_d    = lo_q + LO_W'(WORD_BITS);
              first_d = 1'b0;
              state_d = S_RD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_i.valid) cfg_q <= cfg_i.pages_in_use;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.command;
      pos_q  <= req_i.bit_index;
      end_q  <= req_i.range_end;
      val_q  <= req_i.bit_value;
      widx_q <= req_i.word_index;
      opw_q  <= req_i.operand_word[WORD_BITS-1:0];
      mop_q  <= req_i.merge_op;
    end
    q_q     <= q_d;
    used_q  <= used_d;
    nbits_q <= nbits_d;
    w_q     <= w_d;
    lo_q    <= lo_d;
    first_q <= first_d;
    flag_q  <= flag_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
    if (out_load) begin
      out_flag_q  <= flag_q;
      out_found_q <= found_q;
      out_fidx_q  <= fidx_q;
    end
  end

  // Word memory: one port, either a read or a write in a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

endmodule

// ===== hdl/bscf_checker.sv =====
`include "bitmap_set_clear_find_engine_assert.svh"

module bscf_checker import bscf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              flag,
  input logic              found,
  input logic [FIDX_W-1:0] found_index
);

  // A result that is not taken stays offered, with the same payload.
  `BSCF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `BSCF_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, $stable({flag, found, found_index}))

  // Items are worked on one at a time.
  `BSCF_ASSERT_NXT(a_one_item, clk_i, rst_ni, in_valid && in_ready, !in_ready)

  // Only a find reports a position, and a find never reports a change.
  `BSCF_ASSERT_IMP(a_result_shape, clk_i, rst_ni, out_valid, !(found && flag) && (found || (found_index == '0)))

endmodule

bind bitmap_set_clear_find_engine bscf_checker u_bscf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .flag       (rsp_o.flag),
  .found      (rsp_o.found),
  .found_index(rsp_o.found_index)
);

// ===== dv/tb_bitmap_set_clear_find_engine.sv =====
module tb_bitmap_set_clear_find_engine import bscf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_BITS = DEF_WORD_BITS;
  localparam int unsigned PAGES     = DEF_PAGES;
  localparam int unsigned MAX_POS   = (1 << POS_W) - 1;
  localparam int unsigned MAX_END   = (1 << END_W) - 1;
  localparam int CYCLE_LIMIT        = 500000;

  // Codes the package leaves undefined; the block must treat them as no-ops.
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_W'(CMD_MERGE + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
  localparam logic [MOP_W-1:0] MOP_UNUSED       = '1;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  bit_index;
    logic [END_W-1:0]  range_end;
    logic              bit_value;
    logic [WIDX_W-1:0] word_index;
    logic [OPW_W-1:0]  operand_word;
    logic [MOP_W-1:0]  merge_op;
  } bitmap_cmd_t;

  typedef struct {
    logic              flag;
    logic              found;
    logic [FIDX_W-1:0] found_index;
  } bitmap_result_t;

  logic clk_i;
  logic rst_ni;

  bscf_req_if req_if ();
  bscf_rsp_if rsp_if ();
  bscf_cfg_if cfg_if ();

  bitmap_set_clear_find_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Shadow copy of the bitmap and the size register.
  logic [WORD_BITS-1:0] bitmap_model [PAGES];
  logic [CFG_W-1:0]     pages_reg;

  bitmap_result_t pending_results [$];

  int  error_count;
  int  items_sent;
  int  results_checked;
  int  size_settings;
  int  cycle_count;
  int  hold_request;
  bit  source_gaps_on;
  bit  sink_stalls_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned used_words();
    return (pages_reg > PAGES) ? PAGES : int'(pages_reg);
  endfunction

  function automatic bitmap_result_t execute_bitmap_cmd(input bitmap_cmd_t c);
    bitmap_result_t       r;
    int unsigned          used, nbits, pos, to, lo, a, b, p, w;
    logic [WORD_BITS-1:0] old_w, new_w, m;
    r = '{flag: 1'b0, found: 1'b0, found_index: '0};
    used  = used_words();
    nbits = used * WORD_BITS;
    pos   = c.bit_index;
    case (c.command)
      CMD_READ, CMD_WRITE: begin
        if (pos / WORD_BITS < used) begin
          old_w = bitmap_model[pos / WORD_BITS];
          m = {{(WORD_BITS-1){1'b0}}, 1'b1} << (pos % WORD_BITS);
          if (c.command == CMD_READ) begin
            r.flag = |(old_w & m);
          end else begin
            new_w = c.bit_value ? (old_w | m) : (old_w & ~m);
            bitmap_model[pos / WORD_BITS] = new_w;
            r.flag = (new_w != old_w);
          end
        end
      end
      CMD_RANGE: begin
        to = (c.range_end > nbits) ? nbits : c.range_end;
        if (pos < nbits && to > pos) begin
          for (w = pos / WORD_BITS; w < used; w++) begin
            lo = w * WORD_BITS;
            a  = (pos > lo) ? pos : lo;
            b  = (to < lo + WORD_BITS) ? to : lo + WORD_BITS;
            if (b <= a) break;
            // A shift by the full width yields zero, so this also covers a whole word.
            m = ((64'd1 << (b - a)) - 64'd1) << (a - lo);
            old_w = bitmap_model[w];
            new_w = c.bit_value ? (old_w | m) : (old_w & ~m);
            bitmap_model[w] = new_w;
            if (new_w != old_w) r.flag = 1'b1;
          end
        end
      end
      CMD_FIND: begin
        for (p = pos; p < nbits; p++) begin
          if (bitmap_model[p / WORD_BITS][p % WORD_BITS] == c.bit_value) begin
            r.found = 1'b1;
            r.found_index = FIDX_W'(p);
            break;
          end
        end
      end
      CMD_MERGE: begin
        if (c.word_index < used && c.merge_op != MOP_UNUSED) begin
          old_w = bitmap_model[c.word_index];
          case (c.merge_op)
            MOP_OR:  new_w = old_w | c.operand_word[WORD_BITS-1:0];
            MOP_AND: new_w = old_w & c.operand_word[WORD_BITS-1:0];
            default: new_w = old_w ^ c.operand_word[WORD_BITS-1:0];
          endcase
          bitmap_model[c.word_index] = new_w;
          r.flag = (new_w != old_w);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic bitmap_cmd_t random_cmd();
    bitmap_cmd_t c;
    int unsigned nbits, pick, e;
    nbits = used_words() * WORD_BITS;
    c.bit_value    = 1'($urandom_range(0, 1));
    c.word_index   = WIDX_W'(($urandom_range(0, 99) < 85 && used_words() > 0) ?
                     $urandom_range(0, used_words() - 1) : $urandom_range(0, PAGES - 1));
    c.merge_op     = ($urandom_range(0, 99) < 5) ? MOP_UNUSED :
                     MOP_W'($urandom_range(0, 2));
    c.bit_index    = POS_W'((nbits > 0 && $urandom_range(0, 99) < 80) ?
                     $urandom_range(0, nbits - 1) : $urandom_range(0, MAX_POS));
    pick = $urandom_range(0, 99);
    if (pick < 15)      c.operand_word = '1;
    else if (pick < 25) c.operand_word = '0;
    else if (pick < 40) c.operand_word = 64'd1 << $urandom_range(0, OPW_W - 1);
    else                c.operand_word = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 55)      e = c.bit_index + $urandom_range(1, 200);
    else if (pick < 70) e = c.bit_index + $urandom_range(1, 1500);
    else if (pick < 80) e = $urandom_range(0, MAX_POS + 1);
    else if (pick < 88) e = $urandom_range(MAX_POS + 1, MAX_END);
    else if (pick < 94) e = c.bit_index;
    else                e = (c.bit_index > 0) ? $urandom_range(0, c.bit_index - 1) : 0;
    c.range_end = END_W'(e);
    pick = $urandom_range(0, 99);
    if (pick < 15)      c.command = CMD_READ;
    else if (pick < 33) c.command = CMD_WRITE;
    else if (pick < 53) c.command = CMD_RANGE;
    else if (pick < 75) c.command = CMD_FIND;
    else if (pick < 94) c.command = CMD_MERGE;
    else                c.command = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    return c;
  endfunction

  // Called right after a rising edge; returns at the edge of the transfer with
  // valid still high, so back-to-back items need no extra edge.
  task automatic send_item(input bitmap_cmd_t c);
    int gap;
    gap = (source_gaps_on && $urandom_range(0, 1)) ? idle_length() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= c.command;
    req_if.bit_index    <= c.bit_index;
    req_if.range_end    <= c.range_end;
    req_if.bit_value    <= c.bit_value;
    req_if.word_index   <= c.word_index;
    req_if.operand_word <= c.operand_word;
    req_if.merge_op     <= c.merge_op;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(execute_bitmap_cmd(c));
    items_sent++;
  endtask

  task automatic send_bit(input logic [CMD_W-1:0] cmd, input int unsigned pos,
                          input logic val);
    bitmap_cmd_t c;
    c = '{command: cmd, bit_index: POS_W'(pos), range_end: '0, bit_value: val,
          word_index: '0, operand_word: '0, merge_op: MOP_OR};
    send_item(c);
  endtask

  task automatic send_range(input int unsigned pos, input int unsigned e, input logic val);
    bitmap_cmd_t c;
    c = '{command: CMD_RANGE, bit_index: POS_W'(pos), range_end: END_W'(e), bit_value: val,
          word_index: '0, operand_word: '0, merge_op: MOP_OR};
    send_item(c);
  endtask

  task automatic send_merge(input int unsigned widx, input logic [OPW_W-1:0] opw,
                            input logic [MOP_W-1:0] mop);
    bitmap_cmd_t c;
    c = '{command: CMD_MERGE, bit_index: '0, range_end: '0, bit_value: 1'b0,
          word_index: WIDX_W'(widx), operand_word: opw, merge_op: mop};
    send_item(c);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_pages(input logic [CFG_W-1:0] pages);
    cfg_if.valid        <= 1'b1;
    cfg_if.pages_in_use <= pages;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    pages_reg = pages;
    size_settings++;
  endtask

  task automatic test_reset_state();
    send_bit(CMD_READ, 0, 1'b0);
    send_bit(CMD_FIND, 0, 1'b1);
    send_bit(CMD_FIND, MAX_POS, 1'b0);
  endtask

  task automatic test_bit_writes();
    send_bit(CMD_WRITE, 0, 1'b1);
    send_bit(CMD_WRITE, 0, 1'b1);
    send_bit(CMD_WRITE, MAX_POS, 1'b1);
    send_bit(CMD_READ, MAX_POS, 1'b0);
    send_bit(CMD_WRITE, MAX_POS, 1'b0);
    send_bit(CMD_READ, MAX_POS, 1'b0);
  endtask

  task automatic test_range_writes();
    send_range(60, 200, 1'b1);
    send_range(100, 100, 1'b1);
    send_range(300, 250, 1'b1);
    send_range(4000, MAX_END, 1'b0);
    send_range(4090, MAX_POS + 1, 1'b1);
  endtask

  task automatic test_find();
    send_bit(CMD_FIND, 0, 1'b1);
    send_bit(CMD_FIND, 1, 1'b1);
    send_bit(CMD_FIND, 60, 1'b0);
    send_bit(CMD_FIND, 201, 1'b1);
  endtask

  task automatic test_merge();
    send_merge(PAGES - 1, '1, MOP_OR);
    send_merge(PAGES - 1, '0, MOP_AND);
    send_merge(1, 64'hA5A5_5A5A_F0F0_0F0F, MOP_XOR);
    send_merge(0, '1, MOP_UNUSED);
  endtask

  task automatic test_undefined_commands();
    send_bit(CMD_UNUSED_FIRST, 0, 1'b1);
    send_bit(CMD_UNUSED_LAST, MAX_POS, 1'b0);
  endtask

  // Each phase runs at its own bitmap size, including empty, one word and
  // a value past the number of words.
  task automatic test_random_traffic();
    int unsigned sizes  [8];
    int unsigned counts [8];
    sizes  = '{64, 1, 0, 127, 0, 64, 2, 64};
    counts = '{90, 40, 15, 60, 50, 60, 30, 50};
    sizes[4] = $urandom_range(3, 126);
    for (int i = 0; i < 8; i++) begin
      wait_drained();
      write_pages(CFG_W'(sizes[i]));
      source_gaps_on = (i != 5);
      sink_stalls_on = (i != 5);
      repeat (counts[i]) send_item(random_cmd());
    end
  endtask

  // The result side holds off while commands keep coming, so the block backs
  // up and stalls its input; then the sender waits for everything to drain.
  task automatic test_backpressure();
    wait_drained();
    source_gaps_on = 1'b0;
    sink_stalls_on = 1'b1;
    hold_request = 300;
    repeat (30) send_item(random_cmd());
    wait_drained();
    source_gaps_on = 1'b1;
    repeat (10) send_item(random_cmd());
  endtask

  initial begin : result_sink
    int             stall_left;
    int             hold_left;
    bitmap_result_t exp_r;
    stall_left = 0;
    hold_left  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          results_checked++;
          if (rsp_if.flag !== exp_r.flag) begin
            $error("flag mismatch: expected %0d, got %0d", exp_r.flag, rsp_if.flag);
            error_count++;
          end
          if (rsp_if.found !== exp_r.found) begin
            $error("found mismatch: expected %0d, got %0d", exp_r.found, rsp_if.found);
            error_count++;
          end
          if (rsp_if.found_index !== exp_r.found_index) begin
            $error("found_index mismatch: expected %0d, got %0d",
                   exp_r.found_index, rsp_if.found_index);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (sink_stalls_on && $urandom_range(0, 9) < 3) stall_left = idle_length();
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[bitmap_set_clear_find_engine] ERROR");
    $finish;
  end

  initial begin
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    size_settings   = 0;
    hold_request    = 0;
    source_gaps_on  = 1'b1;
    sink_stalls_on  = 1'b1;
    pages_reg       = CFG_RESET;
    for (int i = 0; i < PAGES; i++) bitmap_model[i] = '0;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_READ;
    req_if.bit_index    <= '0;
    req_if.range_end    <= '0;
    req_if.bit_value    <= 1'b0;
    req_if.word_index   <= '0;
    req_if.operand_word <= '0;
    req_if.merge_op     <= MOP_OR;
    cfg_if.valid        <= 1'b0;
    cfg_if.pages_in_use <= CFG_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_bit_writes();
    test_range_writes();
    test_find();
    test_merge();
    test_undefined_commands();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    // Long enough for a full-bitmap search to finish, should anything stray appear.
    repeat (200) @(posedge clk_i);

    $display("Ran %0d commands over %0d bitmap size settings, with stalls on both sides.",
             items_sent, size_settings);
    $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("[bitmap_set_clear_find_engine] OK");
    end else begin
      $display("[bitmap_set_clear_find_engine] ERROR");
    end
    $finish;
  end

endmodule
